### hw/rtl/compact_splat_record_decoder_top_defines.svh
// Assertion macros for the record decoder RTL.
`ifndef COMPACT_SPLAT_RECORD_DECODER_TOP_DEFINES_SVH
`define COMPACT_SPLAT_RECORD_DECODER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define CSRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CSRD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/csrd_pkg.sv
// Types, codes and conversion functions of the compact record decoder.
`default_nettype none
package csrd_pkg;

   localparam int SLOT_W  = 4;
   localparam int VALUE_W = 32;

   localparam logic KIND_VALUE        = 1'b0;
   localparam logic KIND_LENGTH_ERROR = 1'b1;

   localparam logic [SLOT_W-1:0] SLOT_OPACITY = 4'd12;
   localparam logic [SLOT_W-1:0] SLOT_NONE    = 4'd0;

   typedef struct packed {
      logic               kind;
      logic [SLOT_W-1:0]  slot;
      logic [VALUE_W-1:0] value;
      logic               last;
   } result_type;

   typedef logic [31:0] lut_type [256];

   // Rounds a real to the nearest single value, ties to even; normal or zero only.
   function automatic logic [31:0] to_single(real x);
      logic [63:0] d;
      logic [52:0] m;
      logic [24:0] top;
      logic [28:0] rest;
      logic [10:0] e;
      d = $realtobits(x);
      if (d[62:0] == 63'd0) begin
         return {d[63], 31'd0};
      end
      e    = d[62:52];
      m    = {1'b1, d[51:0]};
      top  = {1'b0, m[52:29]};
      rest = m[28:0];
      if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && top[0])) begin
         top = top + 25'd1;
      end
      if (top[24]) begin
         top = top >> 1;
         e   = e + 11'd1;
      end
      return {d[63], 8'(e - 11'd896), top[22:0]};
   endfunction

   function automatic real from_single(logic [31:0] s);
      logic [10:0] e;
      if (s[30:0] == 31'd0) begin
         return 0.0;
      end
      e = 11'(s[30:23]) + 11'd896;
      return $bitstoreal({s[31], e, s[22:0], 29'd0});
   endfunction

   localparam real COLOUR_SCALE = from_single(to_single(0.28209479177387814));

   function automatic lut_type build_colour_lut();
      lut_type t;
      real f1;
      real f2;
      for (int b = 0; b < 256; b++) begin
         f1   = from_single(to_single(real'(b) / 255.0));
         f2   = from_single(to_single(f1 - 0.5));
         t[b] = to_single(f2 / COLOUR_SCALE);
      end
      return t;
   endfunction

   function automatic lut_type build_opacity_lut();
      lut_type t;
      for (int b = 0; b < 256; b++) begin
         t[b] = to_single(real'(b) / 255.0);
      end
      return t;
   endfunction

   localparam lut_type COLOUR_LUT  = build_colour_lut();
   localparam lut_type OPACITY_LUT = build_opacity_lut();

   // Exact widening of a half-precision pattern to single precision.
   function automatic logic [31:0] widen_half(logic [15:0] h);
      logic [4:0] ex;
      logic [9:0] man;
      logic [9:0] norm;
      int         lead;
      ex   = h[14:10];
      man  = h[9:0];
      lead = 0;
      for (int i = 0; i < 10; i++) begin
         if (man[i]) begin
            lead = i;
         end
      end
      norm = 10'(man << (10 - lead));
      if (ex == 5'd0) begin
         if (man == 10'd0) begin
            return {h[15], 31'd0};
         end
         return {h[15], 8'(lead + 103), norm, 13'd0};
      end
      if (ex == 5'h1F) begin
         return {h[15], 8'hFF, man, 13'd0};
      end
      return {h[15], 8'(ex) + 8'd112, man, 13'd0};
   endfunction

endpackage
`default_nettype wire

### hw/rtl/compact_splat_record_decoder_top.sv
// Top level of the compact record decoder.
//
// Payload bytes arrive one per transaction on the req_ channel, with tlast on
// the final byte of the payload. Every RECORD_BYTES bytes form one record; a
// value is decoded in the cycle its last byte is accepted and the result
// transaction is written into the result queue, from which rsp_ offers it.
// Thirteen values leave per record: slots 0-2 centre words, 3-8 widened
// half covariance terms, 9-11 colour coefficients, 12 opacity.
// If tlast comes before a record is complete, a result with tuser set follows
// any value result of that byte and the next byte starts a new record.
// A byte is accepted every cycle while req_tready is high; results go through
// a four-entry queue and req_tready drops only while fewer than two entries are
// free, so one byte per cycle is sustained while the receiver takes one result
// per cycle. When rsp_tready is low the queue fills and then holds req_tready
// low; nothing is lost. Reset empties the queue and returns to the record start.
`default_nettype none
`include "compact_splat_record_decoder_top_defines.svh"
module compact_splat_record_decoder_top
   import csrd_pkg::*;
#(
   parameter int RECORD_BYTES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // payload_byte
   input  wire logic        req_tlast,   // end_of_payload
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // slot[3:0], value_bits[35:4], zero pad
   output      logic        rsp_tuser,   // kind
   output      logic        rsp_tlast    // last
);

   localparam int POS_W = $clog2(RECORD_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(RECORD_BYTES - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [23:0]      pend_ff, pend_in;
   result_type       queue_ff [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;

   logic             req_fire, rsp_fire;
   logic             have, err, wrap;
   logic [6:0]       p;
   logic [SLOT_W-1:0] slot;
   logic [31:0]      bits;
   result_type       first_res, err_res;
   logic [1:0]       n_push;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign p        = 7'(pos_ff);

   always_comb begin
      have = 1'b0;
      slot = SLOT_NONE;
      bits = 32'd0;
      if (p == 7'd3 || p == 7'd7 || p == 7'd11) begin
         have = 1'b1;
         slot = SLOT_W'(p >> 2);
         bits = {req_tdata, pend_ff};
      end else if (p >= 7'd13 && p <= 7'd23 && p[0]) begin
         have = 1'b1;
         slot = SLOT_W'((p - 7'd7) >> 1);
         bits = widen_half({req_tdata, pend_ff[23:16]});
      end else if (p >= 7'd24 && p <= 7'd26) begin
         have = 1'b1;
         slot = SLOT_W'(p - 7'd15);
         bits = COLOUR_LUT[req_tdata];
      end else if (p == 7'd27) begin
         have = 1'b1;
         slot = SLOT_OPACITY;
         bits = OPACITY_LUT[req_tdata];
      end
      wrap = (pos_ff == LAST_POS);
      err  = req_tlast && !wrap;
      first_res = '{kind: KIND_VALUE, slot: slot, value: bits, last: !err};
      err_res   = '{kind: KIND_LENGTH_ERROR, slot: SLOT_NONE, value: 32'd0, last: 1'b1};
      if (!have) begin
         first_res = err_res;
      end
      n_push = req_fire ? (2'(have) + 2'(err)) : 2'd0;
   end

   always_comb begin
      pos_in  = pos_ff;
      pend_in = pend_ff;
      if (req_fire) begin
         pend_in = {req_tdata, pend_ff[23:8]};
         pos_in  = (wrap || err) ? '0 : pos_ff + POS_W'(1);
      end
      wr_ptr_in = wr_ptr_ff + n_push;
      rd_ptr_in = rd_ptr_ff + 2'(rsp_fire);
      count_in  = count_ff + 3'(n_push) - 3'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         pend_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         pend_ff   <= pend_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (n_push == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= err_res;
      end
   end

   assign req_tready = (count_ff <= 3'd2);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {4'd0, queue_ff[rd_ptr_ff].value, queue_ff[rd_ptr_ff].slot};
   assign rsp_tuser  = queue_ff[rd_ptr_ff].kind;
   assign rsp_tlast  = queue_ff[rd_ptr_ff].last;

   `CSRD_ASSERT(a_count_bound, count_ff <= 3'd4, "result queue overflow")
   `CSRD_ASSERT(a_error_shows, (req_fire && err) |=> rsp_tvalid, "length error result missing")
   `CSRD_ASSERT(a_pos_after_end, (req_fire && req_tlast) |=> (pos_ff == '0), "record start not restored after payload end")

endmodule
`default_nettype wire
